### design/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and constants of the nibble stuffing codec.
// ----------------------------------------------------------------------------
package nsc_pkg;

	localparam int FRAME_BYTES_DEF = 8;
	// counters reach FRAME_BYTES+1, at most 15
	localparam int CNT_W  = 4;
	localparam int BYTE_W = 8;
	localparam int NIB_W  = 4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [NIB_W-1:0]  nib_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic KIND_PACKED  = 1'b0;
	localparam logic KIND_DECODED = 1'b1;

	localparam nib_t  NIB_ZERO  = 4'h0;
	localparam byte_t BYTE_ZERO = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENC_SCAN,
		ST_ENC_EMIT,
		ST_DEC_PRE,
		ST_DEC_EMIT
	} state_t;

endpackage

### design/nsc_if.sv
// ----------------------------------------------------------------------------
// nsc_if
// Valid/ready channels of the nibble stuffing codec: request and result items.
// ----------------------------------------------------------------------------
interface nsc_req_if
	import nsc_pkg::*;
;
	logic  valid;
	logic  ready;
	logic  command;
	byte_t in_byte;

	modport source (output valid, output command, output in_byte, input ready);
	modport sink   (input valid, input command, input in_byte, output ready);
endinterface

interface nsc_rsp_if
	import nsc_pkg::*;
;
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  kind;
	logic  error;
	logic  last;

	modport source (output valid, output out_byte, output kind, output error,
		output last, input ready);
	modport sink   (input valid, input out_byte, input kind, input error,
		input last, output ready);
endinterface

### design/nsc_ram.sv
// ----------------------------------------------------------------------------
// nsc_ram
// Byte-wide synchronous RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module nsc_ram
	import nsc_pkg::*;
#(
	parameter int DEPTH = FRAME_BYTES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  byte_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output byte_t         rdata
);

	byte_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/nibble_stuffing_codec.sv
// ----------------------------------------------------------------------------
// nibble_stuffing_codec
// Nibble stuffing encoder and decoder sharing one request and one result channel.
// ----------------------------------------------------------------------------
// req carries items with command and in_byte; rsp carries out_byte, kind,
// error and last. command 0 gathers raw bytes; the FRAME_BYTES-th raw byte
// starts a backward pass over the encode RAM (one read-modify-write per
// cycle) that fills in the marker distances, then the FRAME_BYTES+1 packed
// bytes leave one per cycle while the receiver takes them. command 1 decodes
// a packed byte in the cycle it is accepted; the byte that completes a frame
// is followed by a RAM read state and FRAME_BYTES decoded bytes, one per
// cycle while the receiver takes them. A non-completing item leaves req
// ready; an encode or a decode frame end holds req off through the scan or
// RAM read and the emission, longer during a receiver stall, as set by the
// single read port of each RAM and the output register.
// While the receiver stalls, the output register holds its item and frame
// emission pauses; req is ready again once the last item of the frame is in
// the output register.
// Reset clears counters, decoder status and the state machine; the RAMs are
// not cleared, every entry is written before it is read.
// ----------------------------------------------------------------------------
module nibble_stuffing_codec
	import nsc_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	nsc_req_if.sink   req,
	nsc_rsp_if.source rsp
);

	localparam int   AW  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam cnt_t N_C = CNT_W'(FRAME_BYTES);
	localparam cnt_t NM1 = CNT_W'(FRAME_BYTES - 1);
	localparam cnt_t NP1 = CNT_W'(FRAME_BYTES + 1);

	state_t state_q, state_d;

	cnt_t  enc_count_q, enc_count_d;
	cnt_t  dec_count_q, dec_count_d;
	nib_t  countdown_q, countdown_d;
	logic  failed_q, failed_d;

	cnt_t  scan_idx_q, scan_idx_d;
	logic  scan_more_q, scan_more_d;
	logic  scan_pend_s1, scan_pend_d;
	cnt_t  scan_addr_s1, scan_addr_d;
	cnt_t  next_q, next_d;
	byte_t first_q, first_d;
	cnt_t  emit_q, emit_d;

	logic  out_valid_q;
	byte_t out_byte_q;
	logic  out_kind_q, out_error_q, out_last_q;
	logic  out_load;
	byte_t out_byte_d;
	logic  out_kind_d, out_error_d, out_last_d;

	logic          enc_we, enc_re, dec_we, dec_re;
	logic [AW-1:0] enc_waddr, enc_raddr, dec_waddr, dec_raddr;
	byte_t         enc_wdata, enc_rdata, dec_wdata, dec_rdata;

	logic  in_fire, slot_free;
	nib_t  b_hi, b_lo;
	cnt_t  cnt_eff, pos, dec_idx;
	byte_t dec_val;

	nsc_ram #(.DEPTH(FRAME_BYTES), .AW(AW)) u_enc_ram (
		.clk   (clk),
		.we    (enc_we),
		.waddr (enc_waddr),
		.wdata (enc_wdata),
		.re    (enc_re),
		.raddr (enc_raddr),
		.rdata (enc_rdata)
	);

	nsc_ram #(.DEPTH(FRAME_BYTES), .AW(AW)) u_dec_ram (
		.clk   (clk),
		.we    (dec_we),
		.waddr (dec_waddr),
		.wdata (dec_wdata),
		.re    (dec_re),
		.raddr (dec_raddr),
		.rdata (dec_rdata)
	);

	assign req.ready    = (state_q == ST_IDLE);
	assign in_fire      = req.valid && req.ready;
	assign slot_free    = !out_valid_q || rsp.ready;

	assign rsp.valid    = out_valid_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.kind     = out_kind_q;
	assign rsp.error    = out_error_q;
	assign rsp.last     = out_last_q;

	assign b_hi    = req.in_byte[7:4];
	assign b_lo    = req.in_byte[3:0];
	// a byte with a zero high nibble is a delimiter and restarts the frame
	assign cnt_eff = (b_hi == NIB_ZERO) ? '0 : dec_count_q;
	assign dec_idx = cnt_eff - CNT_W'(1);
	assign pos     = scan_addr_s1 + CNT_W'(1);

	always_comb begin
		state_d     = state_q;
		enc_count_d = enc_count_q;
		dec_count_d = dec_count_q;
		countdown_d = countdown_q;
		failed_d    = failed_q;
		scan_idx_d  = scan_idx_q;
		scan_more_d = scan_more_q;
		scan_pend_d = 1'b0;
		scan_addr_d = scan_addr_s1;
		next_d      = next_q;
		first_d     = first_q;
		emit_d      = emit_q;
		out_load    = 1'b0;
		out_byte_d  = out_byte_q;
		out_kind_d  = out_kind_q;
		out_error_d = out_error_q;
		out_last_d  = out_last_q;
		enc_we      = 1'b0;
		enc_waddr   = enc_count_q[AW-1:0];
		enc_wdata   = req.in_byte;
		enc_re      = 1'b0;
		enc_raddr   = scan_idx_q[AW-1:0];
		dec_we      = 1'b0;
		dec_waddr   = dec_idx[AW-1:0];
		dec_wdata   = req.in_byte;
		dec_re      = 1'b0;
		dec_raddr   = '0;
		dec_val     = req.in_byte;

		case (state_q)
			ST_IDLE: begin
				if (in_fire && req.command == CMD_ENCODE) begin
					enc_we = 1'b1;
					if (enc_count_q == NM1) begin
						enc_count_d = '0;
						scan_idx_d  = NM1;
						scan_more_d = 1'b1;
						next_d      = NP1;
						state_d     = ST_ENC_SCAN;
					end else begin
						enc_count_d = enc_count_q + CNT_W'(1);
					end
				end else if (in_fire && cnt_eff < NP1) begin
					if (cnt_eff == '0) begin
						failed_d    = (b_hi != NIB_ZERO);
						countdown_d = b_lo;
					end else begin
						if (countdown_q <= NIB_W'(1)) begin
							countdown_d = b_hi;
							dec_val     = {NIB_ZERO, b_lo};
							if (b_hi == NIB_ZERO) begin
								failed_d = 1'b1;
							end
						end else begin
							countdown_d = countdown_q - NIB_W'(1);
						end
						dec_we    = 1'b1;
						dec_wdata = dec_val;
					end
					dec_count_d = cnt_eff + CNT_W'(1);
					if (cnt_eff == N_C) begin
						state_d = ST_DEC_PRE;
					end
				end else if (in_fire) begin
					dec_count_d = cnt_eff;
				end
			end

			ST_ENC_SCAN: begin
				// read one entry per cycle going down, write back markers in the cycle after the read
				if (scan_more_q) begin
					enc_re      = 1'b1;
					scan_pend_d = 1'b1;
					scan_addr_d = scan_idx_q;
					if (scan_idx_q == '0) begin
						scan_more_d = 1'b0;
					end else begin
						scan_idx_d = scan_idx_q - CNT_W'(1);
					end
				end
				if (scan_pend_s1) begin
					if (enc_rdata[7:4] == NIB_ZERO) begin
						enc_we    = 1'b1;
						enc_waddr = scan_addr_s1[AW-1:0];
						enc_wdata = {NIB_W'(next_q - pos), enc_rdata[3:0]};
						next_d    = pos;
					end
					if (!scan_more_q) begin
						first_d = BYTE_W'(next_d);
						emit_d  = '0;
						state_d = ST_ENC_EMIT;
					end
				end
			end

			ST_ENC_EMIT: begin
				if (slot_free) begin
					out_load    = 1'b1;
					out_byte_d  = (emit_q == '0) ? first_q : enc_rdata;
					out_kind_d  = KIND_PACKED;
					out_error_d = 1'b0;
					out_last_d  = (emit_q == N_C);
					if (emit_q < N_C) begin
						enc_re    = 1'b1;
						enc_raddr = emit_q[AW-1:0];
					end
					emit_d = emit_q + CNT_W'(1);
					if (emit_q == N_C) begin
						state_d = ST_IDLE;
					end
				end
			end

			ST_DEC_PRE: begin
				dec_re  = 1'b1;
				emit_d  = '0;
				state_d = ST_DEC_EMIT;
			end

			ST_DEC_EMIT: begin
				if (slot_free) begin
					out_load    = 1'b1;
					out_byte_d  = failed_q ? BYTE_ZERO : dec_rdata;
					out_kind_d  = KIND_DECODED;
					out_error_d = failed_q;
					out_last_d  = (emit_q == NM1);
					if (emit_q < NM1) begin
						dec_re    = 1'b1;
						dec_raddr = AW'(emit_q + CNT_W'(1));
					end
					emit_d = emit_q + CNT_W'(1);
					if (emit_q == NM1) begin
						state_d = ST_IDLE;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_count_q  <= '0;
			dec_count_q  <= '0;
			countdown_q  <= '0;
			failed_q     <= 1'b0;
			scan_idx_q   <= '0;
			scan_more_q  <= 1'b0;
			scan_pend_s1 <= 1'b0;
			scan_addr_s1 <= '0;
			next_q       <= '0;
			emit_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			enc_count_q  <= enc_count_d;
			dec_count_q  <= dec_count_d;
			countdown_q  <= countdown_d;
			failed_q     <= failed_d;
			scan_idx_q   <= scan_idx_d;
			scan_more_q  <= scan_more_d;
			scan_pend_s1 <= scan_pend_d;
			scan_addr_s1 <= scan_addr_d;
			next_q       <= next_d;
			emit_q       <= emit_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_d;
		if (out_load) begin
			out_byte_q  <= out_byte_d;
			out_kind_q  <= out_kind_d;
			out_error_q <= out_error_d;
			out_last_q  <= out_last_d;
		end
	end

endmodule
